>>> hdl/pinhole_camera_ray_direction_assert.svh
// Assertion macros used by the port-level checker.
`ifndef PINHOLE_CAMERA_RAY_DIRECTION_ASSERT_SVH
`define PINHOLE_CAMERA_RAY_DIRECTION_ASSERT_SVH

// Same-cycle implication, disabled while rst_n is low.
`define PCRD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pcrd assertion failed");

// Next-cycle implication, disabled while rst_n is low.
`define PCRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pcrd assertion failed");

`endif

>>> hdl/pcrd_pkg.sv
// Shared constants and types for the pinhole camera ray direction block.
package pcrd_pkg;

    localparam int IMAGE_WIDTH = 1024;
    localparam int MAX_ROWS    = 4096;

    localparam int PX_W   = 10;
    localparam int PY_W   = 12;
    localparam int STEP_W = 17;
    localparam int VEC_W  = 48;
    localparam int COMP_W = 16;
    localparam int NX_W   = 18;
    localparam int NY_W   = 30;
    localparam int PR_W   = 34;
    localparam int PU_W   = 46;
    localparam int PF_W   = 32;
    localparam int SUM_W  = 48;
    localparam int MAG_W  = 47;
    localparam int POS_W  = 6;
    localparam int NM_W   = 30;
    localparam int SQ_W   = 60;
    localparam int SS_W   = 62;
    localparam int LEN_W  = 31;
    localparam int ISQ_N  = 31;
    localparam int Q_W    = 14;
    localparam int NUM_W  = 45;
    localparam int FRAC_B = 13;
    localparam int NORM_P = 29;

    localparam logic [STEP_W-1:0] STEP_RESET = 17'd128;

    localparam logic [1:0] REG_RIGHT   = 2'd0;
    localparam logic [1:0] REG_UP      = 2'd1;
    localparam logic [1:0] REG_FORWARD = 2'd2;
    localparam logic [1:0] REG_STEP    = 2'd3;

    typedef struct packed {
        logic       zero;
        logic [2:0] neg;
    } sgn_t;

    typedef struct packed {
        sgn_t                 f;
        logic [2:0][NM_W-1:0] nm;
    } carry_t;

endpackage

>>> hdl/pinhole_camera_ray_direction.sv
// Pinhole camera primary ray direction: pixel in, unit direction out.
// Throughput: one beat per cycle; a 54-stage pipeline with a two-entry output buffer.
// The pipeline holds only while the spare output entry is full; one waiting result
// does not stop input. Reset (aresetn low, synchronous) clears all valid bits and
// loads the registers with zero vectors and a row step of 128.
module pinhole_camera_ray_direction
    import pcrd_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [23:0]             s_tdata,   // pixel_x[9:0], pixel_y[21:10], zero fill
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [3*COMP_W-1:0]     m_tdata,   // dir_x[15:0], dir_y[31:16], dir_z[47:32]
    input  logic                    cfg_wr_en,
    input  logic [1:0]              cfg_addr,
    input  logic [VEC_W-1:0]        cfg_wdata
);

    // ---------------- configuration registers ----------------
    logic [VEC_W-1:0]  right_reg, up_reg, fwd_reg;
    logic [STEP_W-1:0] step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            right_reg <= '0;
            up_reg    <= '0;
            fwd_reg   <= '0;
            step_reg  <= STEP_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_RIGHT:   right_reg <= cfg_wdata;
                REG_UP:      up_reg    <= cfg_wdata;
                REG_FORWARD: fwd_reg   <= cfg_wdata;
                REG_STEP:    step_reg  <= cfg_wdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Whole pipeline advances together unless the spare output entry is occupied.
    logic adv;
    logic spare_valid_reg;
    assign adv      = !spare_valid_reg;
    assign s_tready = adv;

    // ---------------- stage 1: normalised device coordinates ----------------
    logic [PX_W-1:0]          px;
    logic [PY_W-1:0]          py, py_sat;
    logic [27:0]              nx_wide;
    logic signed [NX_W-1:0]   s1_nx_next, s1_nx_reg;
    logic signed [NY_W-1:0]   s1_ny_next, s1_ny_reg;
    logic                     s1_vld_reg;

    always_comb begin
        px = s_tdata[PX_W-1:0];
        py = s_tdata[PX_W +: PY_W];
        // saturate rows beyond the limit
        py_sat = (13'(py) >= 13'(MAX_ROWS)) ? PY_W'(MAX_ROWS - 1) : py;
        nx_wide = 28'(({11'd0, px, 7'd0} << 10) / IMAGE_WIDTH);
        s1_nx_next = $signed(NX_W'(nx_wide)) - NX_W'(65536);
        s1_ny_next = $signed(NY_W'(29'(py_sat) * 29'(step_reg))) - NY_W'(65536);
    end

    // ---------------- stage 2: products ----------------
    logic signed [PR_W-1:0] s2_pr_next [3], s2_pr_reg [3];
    logic signed [PU_W-1:0] s2_pu_next [3], s2_pu_reg [3];
    logic signed [PF_W-1:0] s2_pf_next [3], s2_pf_reg [3];
    logic                   s2_vld_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            s2_pr_next[k] = PR_W'(s1_nx_reg) * PR_W'($signed(right_reg[COMP_W*k +: COMP_W]));
            s2_pu_next[k] = PU_W'(s1_ny_reg) * PU_W'($signed(up_reg[COMP_W*k +: COMP_W]));
            s2_pf_next[k] = $signed({fwd_reg[COMP_W*k +: COMP_W], 16'd0});
        end
    end

    // ---------------- stage 3: sum ----------------
    logic signed [SUM_W-1:0] s3_sum_next [3], s3_sum_reg [3];
    logic                    s3_vld_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            s3_sum_next[k] = SUM_W'(s2_pr_reg[k]) + SUM_W'(s2_pu_reg[k])
                           + SUM_W'(s2_pf_reg[k]);
        end
    end

    // ---------------- stage 4: sign and magnitude ----------------
    logic [MAG_W-1:0] s4_mag_next [3], s4_mag_reg [3];
    logic [2:0]       s4_neg_next, s4_neg_reg;
    logic             s4_vld_reg;
    logic [SUM_W-1:0] abs_tmp [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            s4_neg_next[k] = s3_sum_reg[k][SUM_W-1];
            abs_tmp[k]     = s4_neg_next[k] ? SUM_W'(-s3_sum_reg[k]) : SUM_W'(s3_sum_reg[k]);
            s4_mag_next[k] = abs_tmp[k][MAG_W-1:0];
        end
    end

    // ---------------- stage 5: leading one of the largest magnitude ----------------
    // The top set bit of the OR of all magnitudes is that of the maximum.
    logic [MAG_W-1:0] ov;
    logic [POS_W-1:0] s5_pos_next, s5_pos_reg;
    logic             s5_zero_reg;
    logic [MAG_W-1:0] s5_mag_reg [3];
    logic [2:0]       s5_neg_reg;
    logic             s5_vld_reg;

    always_comb begin
        ov = s4_mag_reg[0] | s4_mag_reg[1] | s4_mag_reg[2];
        s5_pos_next = '0;
        for (int b = 0; b < MAG_W; b++) begin
            if (ov[b]) s5_pos_next = POS_W'(b);
        end
    end

    // ---------------- stage 6: normalise into [2^29, 2^30) ----------------
    logic [MAG_W-1:0] sh_tmp [3];
    carry_t           s6_next;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (s5_pos_reg >= POS_W'(NORM_P)) begin
                sh_tmp[k] = s5_mag_reg[k] >> (s5_pos_reg - POS_W'(NORM_P));
            end else begin
                sh_tmp[k] = s5_mag_reg[k] << (POS_W'(NORM_P) - s5_pos_reg);
            end
            s6_next.nm[k] = sh_tmp[k][NM_W-1:0];
        end
        s6_next.f.zero = s5_zero_reg;
        s6_next.f.neg  = s5_neg_reg;
    end

    carry_t           s6_reg;
    logic             s6_vld_reg;

    // ---------------- stage 7: squares ----------------
    logic [SQ_W-1:0]  s7_sq_next [3], s7_sq_reg [3];
    carry_t           s7_reg;
    logic             s7_vld_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            s7_sq_next[k] = SQ_W'(s6_reg.nm[k]) * SQ_W'(s6_reg.nm[k]);
        end
    end

    // ---------------- stage 8 and square root: one result bit per stage ----------------
    logic [SS_W-1:0] rt_rem_reg  [ISQ_N+1];
    logic [SS_W-1:0] rt_root_reg [ISQ_N+1];
    carry_t          rt_car_reg  [ISQ_N+1];
    logic            rt_vld_reg  [ISQ_N+1];

    genvar gi;
    generate
        for (gi = 0; gi < ISQ_N; gi++) begin : g_isqrt
            localparam logic [SS_W-1:0] BITV = SS_W'(1) << (2 * (ISQ_N - 1 - gi));
            logic [SS_W-1:0] trial;
            logic [SS_W-1:0] rem_next, root_next;

            always_comb begin
                trial = rt_root_reg[gi] + BITV;
                if (rt_rem_reg[gi] >= trial) begin
                    rem_next  = rt_rem_reg[gi] - trial;
                    root_next = (rt_root_reg[gi] >> 1) + BITV;
                end else begin
                    rem_next  = rt_rem_reg[gi];
                    root_next = rt_root_reg[gi] >> 1;
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    rt_vld_reg[gi+1] <= 1'b0;
                end else if (adv) begin
                    rt_vld_reg[gi+1] <= rt_vld_reg[gi];
                end
            end

            always_ff @(posedge aclk) begin
                if (adv) begin
                    rt_rem_reg[gi+1]  <= rem_next;
                    rt_root_reg[gi+1] <= root_next;
                    rt_car_reg[gi+1]  <= rt_car_reg[gi];
                end
            end
        end
    endgenerate

    // ---------------- dividend stage: mag*8192 + L/2 ----------------
    logic [LEN_W-1:0] len;
    logic [NUM_W-1:0] num_next [3];

    assign len = rt_root_reg[ISQ_N][LEN_W-1:0];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            num_next[k] = (NUM_W'(rt_car_reg[ISQ_N].nm[k]) << FRAC_B) + NUM_W'(len >> 1);
        end
    end

    // ---------------- restoring division: one quotient bit per stage ----------------
    logic [2:0][NUM_W-1:0] dv_rem_reg [Q_W+1];
    logic [2:0][Q_W-1:0]   dv_q_reg   [Q_W+1];
    logic [LEN_W-1:0]      dv_len_reg [Q_W+1];
    sgn_t                  dv_f_reg   [Q_W+1];
    logic                  dv_vld_reg [Q_W+1];

    generate
        for (gi = 0; gi < Q_W; gi++) begin : g_div
            localparam int SH = Q_W - 1 - gi;
            logic [NUM_W-1:0]      dcmp;
            logic [2:0][NUM_W-1:0] rem_next;
            logic [2:0][Q_W-1:0]   q_next;

            always_comb begin
                dcmp = NUM_W'(dv_len_reg[gi]) << SH;
                for (int k = 0; k < 3; k++) begin
                    q_next[k] = dv_q_reg[gi][k];
                    if (dv_rem_reg[gi][k] >= dcmp) begin
                        rem_next[k]   = dv_rem_reg[gi][k] - dcmp;
                        q_next[k][SH] = 1'b1;
                    end else begin
                        rem_next[k] = dv_rem_reg[gi][k];
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    dv_vld_reg[gi+1] <= 1'b0;
                end else if (adv) begin
                    dv_vld_reg[gi+1] <= dv_vld_reg[gi];
                end
            end

            always_ff @(posedge aclk) begin
                if (adv) begin
                    dv_rem_reg[gi+1] <= rem_next;
                    dv_q_reg[gi+1]   <= q_next;
                    dv_len_reg[gi+1] <= dv_len_reg[gi];
                    dv_f_reg[gi+1]   <= dv_f_reg[gi];
                end
            end
        end
    endgenerate

    // ---------------- sign and zero case on the way into the output buffer ----------------
    logic [3*COMP_W-1:0] push_data;
    logic                push;
    logic [COMP_W-1:0]   qx [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            qx[k] = COMP_W'(dv_q_reg[Q_W][k]);
            if (dv_f_reg[Q_W].zero) begin
                push_data[COMP_W*k +: COMP_W] = '0;
            end else if (dv_f_reg[Q_W].neg[k]) begin
                push_data[COMP_W*k +: COMP_W] = -qx[k];
            end else begin
                push_data[COMP_W*k +: COMP_W] = qx[k];
            end
        end
        push = adv && dv_vld_reg[Q_W];
    end

    // ---------------- pipeline valid bits ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            s3_vld_reg    <= 1'b0;
            s4_vld_reg    <= 1'b0;
            s5_vld_reg    <= 1'b0;
            s6_vld_reg    <= 1'b0;
            s7_vld_reg    <= 1'b0;
            rt_vld_reg[0] <= 1'b0;
            dv_vld_reg[0] <= 1'b0;
        end else if (adv) begin
            s1_vld_reg    <= s_tvalid;
            s2_vld_reg    <= s1_vld_reg;
            s3_vld_reg    <= s2_vld_reg;
            s4_vld_reg    <= s3_vld_reg;
            s5_vld_reg    <= s4_vld_reg;
            s6_vld_reg    <= s5_vld_reg;
            s7_vld_reg    <= s6_vld_reg;
            rt_vld_reg[0] <= s7_vld_reg;
            dv_vld_reg[0] <= rt_vld_reg[ISQ_N];
        end
    end

    // ---------------- pipeline payload ----------------
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_nx_reg   <= s1_nx_next;
            s1_ny_reg   <= s1_ny_next;
            s2_pr_reg   <= s2_pr_next;
            s2_pu_reg   <= s2_pu_next;
            s2_pf_reg   <= s2_pf_next;
            s3_sum_reg  <= s3_sum_next;
            s4_mag_reg  <= s4_mag_next;
            s4_neg_reg  <= s4_neg_next;
            s5_pos_reg  <= s5_pos_next;
            s5_zero_reg <= (ov == '0);
            s5_mag_reg  <= s4_mag_reg;
            s5_neg_reg  <= s4_neg_reg;
            s6_reg      <= s6_next;
            s7_sq_reg   <= s7_sq_next;
            s7_reg      <= s6_reg;
            rt_rem_reg[0]  <= SS_W'(s7_sq_reg[0]) + SS_W'(s7_sq_reg[1]) + SS_W'(s7_sq_reg[2]);
            rt_root_reg[0] <= '0;
            rt_car_reg[0]  <= s7_reg;
            for (int k = 0; k < 3; k++) begin
                dv_rem_reg[0][k] <= num_next[k];
            end
            dv_q_reg[0]   <= '0;
            dv_len_reg[0] <= len;
            dv_f_reg[0]   <= rt_car_reg[ISQ_N].f;
        end
    end

    // ---------------- two-entry output buffer ----------------
    // Head drives the master port; spare catches a beat while the head waits.
    logic                head_valid_reg;
    logic [3*COMP_W-1:0] head_data_reg, spare_data_reg;
    logic                pop;

    assign pop      = head_valid_reg && m_tready;
    assign m_tvalid = head_valid_reg;
    assign m_tdata  = head_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg  <= 1'b0;
            spare_valid_reg <= 1'b0;
        end else begin
            if (!head_valid_reg) begin
                head_valid_reg <= push;
            end else if (pop) begin
                if (spare_valid_reg) begin
                    spare_valid_reg <= push;
                end else begin
                    head_valid_reg <= push;
                end
            end else if (push) begin
                spare_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!head_valid_reg || (pop && !spare_valid_reg)) begin
            head_data_reg <= push_data;
        end else if (pop) begin
            head_data_reg  <= spare_data_reg;
            spare_data_reg <= push_data;
        end else if (push) begin
            spare_data_reg <= push_data;
        end
    end

endmodule

>>> hdl/pcrd_checker.sv
// Port-level checker for the ray direction block, bound to the top level.
`include "pinhole_camera_ray_direction_assert.svh"

module pcrd_checker
    import pcrd_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [3*COMP_W-1:0] m_tdata
);

    logic signed [COMP_W-1:0] dx, dy, dz;
    logic                     in_range;
    assign dx = m_tdata[COMP_W-1:0];
    assign dy = m_tdata[2*COMP_W-1:COMP_W];
    assign dz = m_tdata[3*COMP_W-1:2*COMP_W];
    assign in_range = (dx <= 16'sd8192) && (dx >= -16'sd8192)
                   && (dy <= 16'sd8192) && (dy >= -16'sd8192)
                   && (dz <= 16'sd8192) && (dz >= -16'sd8192);

    // reset empties the output
    `PCRD_ASSERT_NEXT(a_reset_empty, aclk, 1'b1, !aresetn, !m_tvalid)
    // a waiting beat stays
    `PCRD_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    // a waiting beat keeps its payload
    `PCRD_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))
    // unit vector components never exceed one
    `PCRD_ASSERT_IMPLY(a_unit_range, aclk, aresetn, m_tvalid, in_range)

endmodule

bind pinhole_camera_ray_direction pcrd_checker u_pcrd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> test/pcrd_ray_checker.sv
// Watches both channels of the ray direction block, predicts each direction and compares.
module pcrd_ray_checker
    import pcrd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [23:0]          s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [3*COMP_W-1:0]  m_tdata,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_addr,
    input  logic [VEC_W-1:0]     cfg_wdata,
    output int                   mismatch_count,
    output int                   dirs_pending
);

    logic [VEC_W-1:0]  right_vec, up_vec, fwd_vec;
    logic [STEP_W-1:0] row_step;
    logic [3*COMP_W-1:0] dir_queue[$];

    function automatic longint comp_of(logic [VEC_W-1:0] v, int k);
        logic signed [15:0] c;
        c = v[16*k +: 16];
        return longint'(c);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [3*COMP_W-1:0] ray_dir(logic [9:0] px, logic [11:0] py_in);
        longint nx, ny, s, q;
        longint unsigned mag[3], top, sq, len, py;
        logic neg[3];
        logic [3*COMP_W-1:0] res;
        py = py_in;
        if (py >= MAX_ROWS) py = MAX_ROWS - 1;
        nx = longint'((longint'(px) * 131072) / IMAGE_WIDTH) - 65536;
        ny = longint'(py * row_step) - 65536;
        top = 0;
        for (int k = 0; k < 3; k++) begin
            s = nx * comp_of(right_vec, k) + ny * comp_of(up_vec, k)
              + comp_of(fwd_vec, k) * 65536;
            neg[k] = s < 0;
            mag[k] = neg[k] ? -s : s;
            if (mag[k] > top) top = mag[k];
        end
        if (top == 0) return '0;
        while (top >= (64'd1 << 30)) begin
            top >>= 1;
            for (int k = 0; k < 3; k++) mag[k] >>= 1;
        end
        while (top < (64'd1 << 29)) begin
            top <<= 1;
            for (int k = 0; k < 3; k++) mag[k] <<= 1;
        end
        sq = 0;
        for (int k = 0; k < 3; k++) sq += mag[k] * mag[k];
        len = root_floor(sq);
        for (int k = 0; k < 3; k++) begin
            q = (mag[k] * 8192 + (len >> 1)) / len;
            res[16*k +: 16] = neg[k] ? 16'(-q) : 16'(q);
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        logic [3*COMP_W-1:0] want;
        if (!aresetn) begin
            right_vec      <= '0;
            up_vec         <= '0;
            fwd_vec        <= '0;
            row_step       <= STEP_RESET;
            mismatch_count <= 0;
            dir_queue.delete();
            dirs_pending   <= 0;
        end else begin
            // predict with the settings before this edge's write
            if (s_tvalid && s_tready)
                dir_queue.push_back(ray_dir(s_tdata[9:0], s_tdata[21:10]));
            if (m_tvalid && m_tready) begin
                if (dir_queue.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected beat: expected none, got %h", m_tdata);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    want = dir_queue.pop_front();
                    if (want !== m_tdata) begin
                        if (mismatch_count < 10)
                            $display("dir mismatch: expected x %h y %h z %h, got x %h y %h z %h",
                                     want[15:0], want[31:16], want[47:32],
                                     m_tdata[15:0], m_tdata[31:16], m_tdata[47:32]);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            dirs_pending <= dir_queue.size();
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_RIGHT:   right_vec <= cfg_wdata;
                    REG_UP:      up_vec    <= cfg_wdata;
                    REG_FORWARD: fwd_vec   <= cfg_wdata;
                    REG_STEP:    row_step  <= cfg_wdata[STEP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> test/tb_pinhole_camera_ray_direction.sv
// Stimulus and verdict for the pinhole camera ray direction block.
module tb_pinhole_camera_ray_direction;
    import pcrd_pkg::*;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [23:0]         s_tdata;   // pixel_x[9:0], pixel_y[21:10], zero fill
    logic                m_tvalid;
    logic                m_tready;
    logic [3*COMP_W-1:0] m_tdata;   // dir_x[15:0], dir_y[31:16], dir_z[47:32]
    logic                cfg_wr_en;
    logic [1:0]          cfg_addr;
    logic [VEC_W-1:0]    cfg_wdata;
    int                  mismatch_count;
    int                  dirs_pending;

    // percentage of cycles the sender idles and the receiver stalls
    int idle_pct, stall_pct;

    pinhole_camera_ray_direction dut (.*);

    pcrd_ray_checker checker_i (.*);

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    // random stall on the result side, changed at the falling edge
    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    // present one pixel beat and hold it until accepted; valid drops only while idling
    task automatic send_pixel(logic [9:0] px, logic [11:0] py);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, py, px};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // drop valid, drain the pipeline, then leave margin for in-flight work
    task automatic drain;
        s_tvalid <= 1'b0;
        while (dirs_pending != 0) @(negedge aclk);
        repeat (70) @(negedge aclk);
    endtask

    // one write beat, after which the write enable is dropped again
    task automatic write_reg(logic [1:0] idx, logic [VEC_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // random Q2.13 vector, mostly moderate with the odd extreme lane
    function automatic logic [VEC_W-1:0] rand_vec();
        logic [VEC_W-1:0] v;
        for (int k = 0; k < 3; k++)
            v[16*k +: 16] = ($urandom_range(7) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(16383) - 8192);
        return v;
    endfunction

    initial begin
        aresetn   = 0;
        s_tvalid  = 0;
        s_tdata   = '0;
        cfg_wr_en = 0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        idle_pct  = 0;
        stall_pct = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // reset settings: all vectors zero, so every direction is zero
        send_pixel(10'd0, 12'd0);
        send_pixel(10'd1023, 12'd4095);
        drain();

        // directed: simple basis with a forward axis
        write_reg(REG_RIGHT, {16'd0, 16'd0, 16'd8192});
        write_reg(REG_UP, {16'd0, 16'd6144, 16'd0});
        write_reg(REG_FORWARD, {16'd8192, 16'd0, 16'd0});
        write_reg(REG_STEP, VEC_W'(17'd16));
        send_pixel(10'd0, 12'd0);
        send_pixel(10'd512, 12'd4095);
        send_pixel(10'd1023, 12'd2048);
        send_pixel(10'd512, 12'd4095);
        drain();
        // forward set to zero at the centre column: only the up term remains
        write_reg(REG_FORWARD, {16'd0, 16'd0, 16'd0});
        send_pixel(10'd512, 12'd0);
        send_pixel(10'd512, 12'd4095);
        drain();
        // extreme lanes and the largest step
        write_reg(REG_RIGHT, {16'h8000, 16'h7FFF, 16'h8000});
        write_reg(REG_UP, {16'h7FFF, 16'h8000, 16'h7FFF});
        write_reg(REG_FORWARD, {16'hFFFF, 16'h0001, 16'h8000});
        write_reg(REG_STEP, VEC_W'(17'h1FFFF));
        send_pixel(10'd0, 12'd0);
        send_pixel(10'h3FF, 12'hFFF);
        send_pixel(10'h2AA, 12'h555);
        send_pixel(10'h155, 12'hAAA);
        drain();
        write_reg(REG_STEP, VEC_W'(17'd0));
        send_pixel(10'd7, 12'd3000);
        send_pixel(10'd900, 12'd1);
        drain();
        write_reg(REG_STEP, VEC_W'(17'h10000));
        send_pixel(10'd100, 12'd1);
        drain();

        // random phases, reconfigured between each
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 60; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 60; end
                default: begin idle_pct = 25; stall_pct = 25; end
            endcase
            write_reg(REG_RIGHT, rand_vec());
            write_reg(REG_UP, rand_vec());
            write_reg(REG_FORWARD, rand_vec());
            write_reg(REG_STEP, VEC_W'(($urandom_range(3) == 0) ? $urandom_range(17'h1FFFF)
                                                                : $urandom_range(512)));
            for (int i = 0; i < 250; i++) begin
                send_pixel(10'($urandom), 12'($urandom));
                // let the pipeline empty once mid-phase
                if (i == 125) drain();
            end
            idle_pct  = 0;
            stall_pct = 0;
            drain();
        end

        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // hang guard
    initial begin
        #4000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> pinhole_camera_ray_direction.f
+incdir+hdl
hdl/pcrd_pkg.sv
hdl/pinhole_camera_ray_direction.sv
hdl/pcrd_checker.sv
test/pcrd_ray_checker.sv
test/tb_pinhole_camera_ray_direction.sv
